### hdl/blsv_pkg.sv
// ----------------------------------------------------------------------------
// blsv_pkg
// Shared types and constants for the brace-list stream validator.
// ----------------------------------------------------------------------------
package blsv_pkg;

  typedef enum logic [2:0] {
    M_VALUE  = 3'd0,
    M_DELIM  = 3'd1,
    M_STRING = 3'd2,
    M_QUOTE  = 3'd3,
    M_TOKEN  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    NS_START  = 3'd0,
    NS_MINUS  = 3'd1,
    NS_INT    = 3'd2,
    NS_FRAC   = 3'd3,
    NS_E      = 3'd4,
    NS_EMINUS = 3'd5,
    NS_EXP    = 3'd6,
    NS_BAD    = 3'd7
  } num_t;

  typedef enum logic [1:0] {
    LK_START  = 2'd0,
    LK_DIGITS = 2'd1,
    LK_HEX    = 2'd2,
    LK_BAD    = 2'd3
  } link_t;

  localparam logic [3:0] VC_STRING = 4'd0;
  localparam logic [3:0] VC_INT    = 4'd1;
  localparam logic [3:0] VC_EXP    = 4'd2;
  localparam logic [3:0] VC_GUID   = 4'd3;
  localparam logic [3:0] VC_B64TAG = 4'd4;
  localparam logic [3:0] VC_LINK   = 4'd5;
  localparam logic [3:0] VC_B64    = 4'd6;
  localparam logic [3:0] VC_DATA   = 4'd7;
  localparam logic [3:0] VC_UNKNOWN = 4'd8;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_CLOSE    = 3'd1;
  localparam logic [2:0] E_DELIM    = 3'd2;
  localparam logic [2:0] E_UNKNOWN  = 3'd3;
  localparam logic [2:0] E_UNFIN    = 3'd4;
  localparam logic [2:0] E_MISSING  = 3'd5;

  // Result word as it travels through the queue
  typedef struct packed {
    logic        stream_valid;
    logic        stream_done;
    logic [2:0]  error_code;
    logic [15:0] depth;
    logic [3:0]  value_class;
    logic        value_done;
  } res_t;

  function automatic logic is_dig(input logic [15:0] c);
    return c >= 16'h30 && c <= 16'h39;
  endfunction

  function automatic logic is_hex(input logic [15:0] c);
    return is_dig(c) || (c >= 16'h61 && c <= 16'h66) || (c >= 16'h41 && c <= 16'h46);
  endfunction

  function automatic logic is_b64(input logic [15:0] c);
    return (c >= 16'h61 && c <= 16'h7A) || (c >= 16'h41 && c <= 16'h5A) || is_dig(c) ||
           c == 16'h2B || c == 16'h3D || c == 16'h2F || c == 16'h0D || c == 16'h0A;
  endfunction

  function automatic logic is_ws(input logic [15:0] c);
    return c == 16'h20 || c == 16'h09 || c == 16'h0D || c == 16'h0A;
  endfunction

  function automatic logic [15:0] tag_b64(input logic [2:0] i);
    logic [15:0] r;
    case (i)
      3'd0: r = 16'h23;
      3'd1: r = 16'h62;
      3'd2: r = 16'h61;
      3'd3: r = 16'h73;
      3'd4: r = 16'h65;
      3'd5: r = 16'h36;
      3'd6: r = 16'h34;
      default: r = 16'h3A;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] tag_data(input logic [2:0] i);
    logic [15:0] r;
    case (i)
      3'd0: r = 16'h23;
      3'd1: r = 16'h64;
      3'd2: r = 16'h61;
      3'd3: r = 16'h74;
      3'd4: r = 16'h61;
      default: r = 16'h3A;
    endcase
    return r;
  endfunction

endpackage

### hdl/brace_list_stream_validator.sv
// ----------------------------------------------------------------------------
// brace_list_stream_validator
// Validates a brace-nested comma-separated character stream, one word a cycle while the queue has room.
// ----------------------------------------------------------------------------
// The result word is written into the result queue when the input word is accepted.
// Accepts one word per cycle while the queue is not full; each word updates the parser state registers.
// A two-entry queue lets input continue while the output side stalls, until both entries are full.
// Reset: synchronous active-low rst_n; parser returns to expecting-value state.
module brace_list_stream_validator #(
  parameter int NEST_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // value_done, value_class, depth, error_code
  output logic        out_tlast,  // stream_done
  output logic        out_tuser   // stream_valid
);

  blsv_pkg::res_t res, q_out;
  logic           step, full;

  assign in_tready = !full;
  assign step      = in_tvalid && in_tready;

  blsv_front #(.NEST_BITS(NEST_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .step(step), .ch(in_tdata), .last(in_tlast), .res(res)
  );

  blsv_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(step), .wr_data(res), .full(full),
    .rd_valid(out_tvalid), .rd_en(out_tvalid && out_tready), .rd_data(q_out)
  );

  assign out_tdata = {q_out.error_code, q_out.depth, q_out.value_class, q_out.value_done};
  assign out_tlast = q_out.stream_done;
  assign out_tuser = q_out.stream_valid;

endmodule

### hdl/blsv_front.sv
// ----------------------------------------------------------------------------
// blsv_front
// Parses one character per cycle when step is high, classifies tokens, builds the result word.
// ----------------------------------------------------------------------------
module blsv_front #(
  parameter int NEST_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [15:0]         ch,
  input  logic                last,
  output blsv_pkg::res_t      res
);

  localparam logic [NEST_BITS-1:0] NEST_ONE = NEST_BITS'(1);

  blsv_pkg::mode_t        mode_r, mode_nxt;
  logic [NEST_BITS-1:0]   nest_r, nest_nxt;
  logic                   ok_r, ok_nxt;
  logic                   stop_r, stop_nxt;
  logic [5:0]             len_r, len_nxt;
  blsv_pkg::num_t         num_r, num_nxt;
  logic [3:0]             flg_r, flg_nxt;   // guid, b64tag, b64, data
  blsv_pkg::link_t        lk_r, lk_nxt;
  logic [5:0]             lkc_r, lkc_nxt;

  logic [5:0]             f_len;
  blsv_pkg::num_t         f_num;
  logic [3:0]             f_flg;
  blsv_pkg::link_t        f_lk;
  logic [5:0]             f_lkc;
  logic [5:0]             t_len;
  blsv_pkg::num_t         t_num;
  logic [3:0]             t_flg;
  blsv_pkg::link_t        t_lk;
  logic [5:0]             t_lkc;
  logic [3:0]             cls;
  logic                   ends, bad, vdone, sdone;
  logic [3:0]             vclass;
  logic [2:0]             err;
  logic                   ok_w;
  logic                   do_tok_start;

  function automatic logic [3:0] cls_of_fed(input blsv_pkg::num_t nm, input logic [3:0] fl,
                                            input blsv_pkg::link_t lk, input logic [5:0] lc,
                                            input logic [5:0] ln);
    logic [3:0] r;
    if (nm == blsv_pkg::NS_INT) r = blsv_pkg::VC_INT;
    else if (nm == blsv_pkg::NS_FRAC || nm == blsv_pkg::NS_EXP) r = blsv_pkg::VC_EXP;
    else if (fl[0] && ln == 6'd36) r = blsv_pkg::VC_GUID;
    else if (fl[1] && ln >= 6'd8) r = blsv_pkg::VC_B64TAG;
    else if (lk == blsv_pkg::LK_HEX && lc == 6'd32) r = blsv_pkg::VC_LINK;
    else if (fl[2]) r = blsv_pkg::VC_B64;
    else if (fl[3] && ln >= 6'd6) r = blsv_pkg::VC_DATA;
    else r = blsv_pkg::VC_UNKNOWN;
    return r;
  endfunction

  // token checkers, fed from either the running state or a fresh start
  always_comb begin
    logic e;
    t_len = do_tok_start ? 6'd0 : len_r;
    t_num = do_tok_start ? blsv_pkg::NS_START : num_r;
    t_flg = do_tok_start ? 4'hF : flg_r;
    t_lk  = do_tok_start ? blsv_pkg::LK_START : lk_r;
    t_lkc = do_tok_start ? 6'd0 : lkc_r;
    e = ch == 16'h65 || ch == 16'h45;
    case (t_num)
      blsv_pkg::NS_START: f_num = ch == 16'h2D ? blsv_pkg::NS_MINUS :
                                  (blsv_pkg::is_dig(ch) ? blsv_pkg::NS_INT : blsv_pkg::NS_BAD);
      blsv_pkg::NS_MINUS: f_num = blsv_pkg::is_dig(ch) ? blsv_pkg::NS_INT : blsv_pkg::NS_BAD;
      blsv_pkg::NS_INT:   f_num = blsv_pkg::is_dig(ch) ? blsv_pkg::NS_INT :
                                  (ch == 16'h2E ? blsv_pkg::NS_FRAC :
                                  (e ? blsv_pkg::NS_E : blsv_pkg::NS_BAD));
      blsv_pkg::NS_FRAC:  f_num = blsv_pkg::is_dig(ch) ? blsv_pkg::NS_FRAC :
                                  (e ? blsv_pkg::NS_E : blsv_pkg::NS_BAD);
      blsv_pkg::NS_E:     f_num = ch == 16'h2D ? blsv_pkg::NS_EMINUS :
                                  (blsv_pkg::is_dig(ch) ? blsv_pkg::NS_EXP : blsv_pkg::NS_BAD);
      blsv_pkg::NS_EMINUS, blsv_pkg::NS_EXP:
                          f_num = blsv_pkg::is_dig(ch) ? blsv_pkg::NS_EXP : blsv_pkg::NS_BAD;
      default:            f_num = blsv_pkg::NS_BAD;
    endcase
    f_flg = t_flg;
    if (t_len >= 6'd36) f_flg[0] = 1'b0;
    else if (t_len == 6'd8 || t_len == 6'd13 || t_len == 6'd18 || t_len == 6'd23) begin
      if (ch != 16'h2D) f_flg[0] = 1'b0;
    end else if (!blsv_pkg::is_hex(ch)) f_flg[0] = 1'b0;
    if (t_len < 6'd8) begin
      if (ch != blsv_pkg::tag_b64(t_len[2:0])) f_flg[1] = 1'b0;
    end else if (!blsv_pkg::is_b64(ch)) f_flg[1] = 1'b0;
    if (!blsv_pkg::is_b64(ch)) f_flg[2] = 1'b0;
    if (t_len < 6'd6) begin
      if (ch != blsv_pkg::tag_data(t_len[2:0])) f_flg[3] = 1'b0;
    end else if (!blsv_pkg::is_b64(ch)) f_flg[3] = 1'b0;
    f_lk = t_lk;
    f_lkc = t_lkc;
    case (t_lk)
      blsv_pkg::LK_START: f_lk = blsv_pkg::is_dig(ch) ? blsv_pkg::LK_DIGITS : blsv_pkg::LK_BAD;
      blsv_pkg::LK_DIGITS: begin
        if (ch == 16'h3A) begin
          f_lk = blsv_pkg::LK_HEX;
          f_lkc = 6'd0;
        end else if (!blsv_pkg::is_dig(ch)) f_lk = blsv_pkg::LK_BAD;
      end
      blsv_pkg::LK_HEX: begin
        if (blsv_pkg::is_hex(ch) && t_lkc < 6'd32) f_lkc = t_lkc + 6'd1;
        else f_lk = blsv_pkg::LK_BAD;
      end
      default: f_lk = blsv_pkg::LK_BAD;
    endcase
    f_len = t_len < 6'd63 ? t_len + 6'd1 : 6'd63;
  end

  always_comb begin
    if (num_r == blsv_pkg::NS_INT) cls = blsv_pkg::VC_INT;
    else if (num_r == blsv_pkg::NS_FRAC || num_r == blsv_pkg::NS_EXP) cls = blsv_pkg::VC_EXP;
    else if (flg_r[0] && len_r == 6'd36) cls = blsv_pkg::VC_GUID;
    else if (flg_r[1] && len_r >= 6'd8) cls = blsv_pkg::VC_B64TAG;
    else if (lk_r == blsv_pkg::LK_HEX && lkc_r == 6'd32) cls = blsv_pkg::VC_LINK;
    else if (flg_r[2]) cls = blsv_pkg::VC_B64;
    else if (flg_r[3] && len_r >= 6'd6) cls = blsv_pkg::VC_DATA;
    else cls = blsv_pkg::VC_UNKNOWN;
  end

  always_comb begin
    logic [NEST_BITS-1:0] n;
    blsv_pkg::mode_t      m;
    logic                 tok_active;
    ends = ch == 16'h0 || last;
    bad = 1'b0;
    vdone = 1'b0;
    vclass = blsv_pkg::VC_STRING;
    err = blsv_pkg::E_NONE;
    ok_w = ok_r;
    do_tok_start = 1'b0;
    n = nest_r;
    m = mode_r;
    sdone = 1'b0;
    tok_active = 1'b0;
    if (ch != 16'h0) begin
      case (mode_r)
        blsv_pkg::M_DELIM: begin
          if (blsv_pkg::is_ws(ch)) m = mode_r;
          else if (ch == 16'h2C) m = blsv_pkg::M_VALUE;
          else if (ch == 16'h7D) begin
            if (n == '0) begin
              err = blsv_pkg::E_CLOSE;
              ok_w = 1'b0;
            end else n = n - NEST_ONE;
          end else bad = 1'b1;
        end
        blsv_pkg::M_STRING: begin
          if (ch == 16'h22) m = blsv_pkg::M_QUOTE;
        end
        blsv_pkg::M_QUOTE: begin
          if (ch == 16'h22) m = blsv_pkg::M_STRING;
          else begin
            vdone = 1'b1;
            if (blsv_pkg::is_ws(ch)) m = blsv_pkg::M_DELIM;
            else if (ch == 16'h2C) m = blsv_pkg::M_VALUE;
            else if (ch == 16'h7D) begin
              m = blsv_pkg::M_DELIM;
              if (n == '0) begin
                err = blsv_pkg::E_CLOSE;
                ok_w = 1'b0;
              end else n = n - NEST_ONE;
            end else bad = 1'b1;
          end
        end
        blsv_pkg::M_TOKEN: begin
          if (ch == 16'h2C || ch == 16'h7D) begin
            vdone = 1'b1;
            vclass = cls;
            if (cls == blsv_pkg::VC_UNKNOWN) begin
              err = blsv_pkg::E_UNKNOWN;
              ok_w = 1'b0;
            end
            if (ch == 16'h7D) begin
              m = blsv_pkg::M_DELIM;
              if (n == '0) begin
                if (err == blsv_pkg::E_NONE) err = blsv_pkg::E_CLOSE;
                ok_w = 1'b0;
              end else n = n - NEST_ONE;
            end else m = blsv_pkg::M_VALUE;
          end else begin
            tok_active = 1'b1;
          end
        end
        default: begin
          if (blsv_pkg::is_ws(ch) || ch == 16'h2C) m = mode_r;
          else if (ch == 16'h22) m = blsv_pkg::M_STRING;
          else if (ch == 16'h7B) begin
            if (n != '1) n = n + NEST_ONE;
          end else if (ch == 16'h7D) begin
            m = blsv_pkg::M_DELIM;
            if (n == '0) begin
              err = blsv_pkg::E_CLOSE;
              ok_w = 1'b0;
            end else n = n - NEST_ONE;
          end else begin
            do_tok_start = 1'b1;
            tok_active = 1'b1;
            m = blsv_pkg::M_TOKEN;
          end
        end
      endcase
    end
    // token feed updates class state before end-of-stream classification
    if (bad) begin
      if (err == blsv_pkg::E_NONE) err = blsv_pkg::E_DELIM;
      ok_w = 1'b0;
      sdone = 1'b1;
    end else if (ends) begin
      if (m == blsv_pkg::M_TOKEN) begin
        vdone = 1'b1;
        vclass = tok_active ? cls_of_fed(f_num, f_flg, f_lk, f_lkc, f_len) : cls;
        if (vclass == blsv_pkg::VC_UNKNOWN) begin
          if (err == blsv_pkg::E_NONE) err = blsv_pkg::E_UNKNOWN;
          ok_w = 1'b0;
        end
      end else if (m == blsv_pkg::M_QUOTE) begin
        vdone = 1'b1;
        vclass = blsv_pkg::VC_STRING;
      end else if (m != blsv_pkg::M_DELIM) begin
        if (err == blsv_pkg::E_NONE) err = blsv_pkg::E_UNFIN;
        ok_w = 1'b0;
      end
      if (n != '0) begin
        if (err == blsv_pkg::E_NONE) err = blsv_pkg::E_MISSING;
        ok_w = 1'b0;
      end
      sdone = 1'b1;
    end

    res.value_done   = vdone;
    res.value_class  = vdone ? vclass : blsv_pkg::VC_STRING;
    res.depth        = 16'(n);
    res.error_code   = err;
    res.stream_done  = sdone;
    res.stream_valid = sdone && ok_w;

    mode_nxt = m;
    nest_nxt = n;
    ok_nxt   = ok_w;
    stop_nxt = 1'b0;
    len_nxt  = tok_active ? f_len : len_r;
    num_nxt  = tok_active ? f_num : num_r;
    flg_nxt  = tok_active ? f_flg : flg_r;
    lk_nxt   = tok_active ? f_lk : lk_r;
    lkc_nxt  = tok_active ? f_lkc : lkc_r;
    if (sdone) begin
      mode_nxt = blsv_pkg::M_VALUE;
      nest_nxt = '0;
      ok_nxt   = 1'b1;
      stop_nxt = bad && !ends;
      len_nxt  = 6'd0;
      num_nxt  = blsv_pkg::NS_START;
      flg_nxt  = 4'hF;
      lk_nxt   = blsv_pkg::LK_START;
      lkc_nxt  = 6'd0;
    end
    if (stop_r) begin
      res = '0;
      mode_nxt = mode_r;
      nest_nxt = nest_r;
      ok_nxt   = ok_r;
      stop_nxt = !ends;
      len_nxt  = len_r;
      num_nxt  = num_r;
      flg_nxt  = flg_r;
      lk_nxt   = lk_r;
      lkc_nxt  = lkc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= blsv_pkg::M_VALUE;
      nest_r <= '0;
      ok_r   <= 1'b1;
      stop_r <= 1'b0;
      len_r  <= 6'd0;
      num_r  <= blsv_pkg::NS_START;
      flg_r  <= 4'hF;
      lk_r   <= blsv_pkg::LK_START;
      lkc_r  <= 6'd0;
    end else if (step) begin
      mode_r <= mode_nxt;
      nest_r <= nest_nxt;
      ok_r   <= ok_nxt;
      stop_r <= stop_nxt;
      len_r  <= len_nxt;
      num_r  <= num_nxt;
      flg_r  <= flg_nxt;
      lk_r   <= lk_nxt;
      lkc_r  <= lkc_nxt;
    end
  end

  a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    step && stop_r |-> res == '0)
    else $error("stopped stream produced a nonzero result");
  a_done_resets: assert property (@(posedge clk) disable iff (!rst_n)
    step && !stop_r && res.stream_done |=> nest_r == '0 && mode_r == blsv_pkg::M_VALUE)
    else $error("state not cleared after stream end");
  a_valid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.stream_valid |-> res.error_code == blsv_pkg::E_NONE)
    else $error("valid stream with error code");

endmodule

### hdl/blsv_queue.sv
// ----------------------------------------------------------------------------
// blsv_queue
// Two-entry result queue between the parser and the output port.
// ----------------------------------------------------------------------------
module blsv_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  blsv_pkg::res_t wr_data,
  output logic           full,
  output logic           rd_valid,
  input  logic           rd_en,
  output blsv_pkg::res_t rd_data
);

  blsv_pkg::res_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full     = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
    else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n) rd_en |-> rd_valid)
    else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule
